### sv/fbpa_pkg.sv
// Shared types, codes and sizes for the fixed block pool allocator.
// No dependencies; used by every module of the block.
package fbpa_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ADDR_W     = 32;
    localparam int BYTES_W    = 16;
    localparam int PROD_W     = IDX_W + BYTES_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_ADDRESS = 2'd0,
        CFG_BLOCK_BYTES  = 2'd1,
        CFG_BLOCK_COUNT  = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [IDX_W-1:0] return_index;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  granted_index;
        logic [ADDR_W-1:0] granted_address;
        logic [CNT_W-1:0]  free_count;
        logic [CNT_W-1:0]  used_count;
    } rsp_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // take request, launch link read and multiply
        logic commit;   // update list, load response register
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic rsp_slot_free;
    } dp_status_t;

endpackage

### sv/fbpa_ctrl.sv
// Sequencer for the fixed block pool allocator: accept, then commit.
// Depends on fbpa_pkg.
module fbpa_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  fbpa_pkg::dp_status_t   dp_status,
    output fbpa_pkg::ctrl_cmd_t    dp_cmd
);

    fbpa_pkg::state_t state_reg;
    fbpa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fbpa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fbpa_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = fbpa_pkg::ST_EXEC;
                end
            end
            fbpa_pkg::ST_EXEC:
            begin
                if (dp_status.rsp_slot_free)
                begin
                    state_next = fbpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fbpa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready      = 1'b0;
        dp_cmd.capture = 1'b0;
        dp_cmd.commit  = 1'b0;
        case (state_reg)
            fbpa_pkg::ST_IDLE:
            begin
                req_ready      = 1'b1;
                dp_cmd.capture = req_valid;
            end
            fbpa_pkg::ST_EXEC:
            begin
                dp_cmd.commit = dp_status.rsp_slot_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

### sv/fbpa_datapath.sv
// Datapath: config registers, link memory with valid bits, list head,
// free count, address multiply and the response register. Depends on fbpa_pkg.
module fbpa_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  fbpa_pkg::req_t                       req,
    input  fbpa_pkg::ctrl_cmd_t                  dp_cmd,
    output fbpa_pkg::dp_status_t                 dp_status,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output fbpa_pkg::rsp_t                       rsp
);

    localparam int IDX_W = fbpa_pkg::IDX_W;
    localparam int CNT_W = fbpa_pkg::CNT_W;

    // clamp block_count to 1..MAX_BLOCKS
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        begin
            r = c;
            if (c == '0)
            begin
                r = CNT_W'(1);
            end
            else if (c > CNT_W'(fbpa_pkg::MAX_BLOCKS))
            begin
                r = CNT_W'(fbpa_pkg::MAX_BLOCKS);
            end
            return r;
        end
    endfunction

    logic [fbpa_pkg::ADDR_W-1:0]  base_reg;
    logic [fbpa_pkg::BYTES_W-1:0] bytes_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             head_reg;
    logic [CNT_W-1:0]             head_next;
    logic [CNT_W-1:0]             free_reg;
    logic [CNT_W-1:0]             free_next;
    logic [fbpa_pkg::MAX_BLOCKS-1:0] link_vld_reg;

    logic [CNT_W-1:0] link_mem [fbpa_pkg::MAX_BLOCKS];

    fbpa_pkg::cmd_t              cmd_reg;
    logic [IDX_W-1:0]            ret_reg;
    logic [CNT_W-1:0]            link_rd_reg;
    logic                        link_vld_rd_reg;
    logic [fbpa_pkg::PROD_W-1:0] prod_reg;

    logic                        rsp_valid_reg;
    fbpa_pkg::rsp_t              rsp_reg;
    fbpa_pkg::rsp_t              rsp_next;

    logic [CNT_W-1:0] eff_count;
    logic             get_ok;
    logic             pool_full;
    logic             put_ok;
    logic             cfg_count_wr;

    assign eff_count    = clamp_count(count_reg);
    assign get_ok       = (free_reg != '0);
    assign pool_full    = (free_reg >= eff_count);
    assign put_ok       = !pool_full && ({1'b0, ret_reg} < eff_count);
    assign cfg_count_wr = cfg_we && (cfg_index == fbpa_pkg::CFG_BLOCK_COUNT);

    always_comb
    begin
        head_next = head_reg;
        free_next = free_reg;
        rsp_next.status          = fbpa_pkg::STATUS_OK;
        rsp_next.granted_index   = '0;
        rsp_next.granted_address = '0;
        if (cmd_reg == fbpa_pkg::CMD_GET)
        begin
            if (get_ok)
            begin
                rsp_next.granted_index   = head_reg[IDX_W-1:0];
                rsp_next.granted_address = base_reg
                    + fbpa_pkg::ADDR_W'(prod_reg);
                if (!head_reg[CNT_W-1])
                begin
                    // unwritten entry still holds its initial link: i + 1
                    head_next = link_vld_rd_reg ? link_rd_reg : head_reg + CNT_W'(1);
                end
                free_next = free_reg - CNT_W'(1);
            end
            else
            begin
                rsp_next.status = fbpa_pkg::STATUS_EMPTY;
            end
        end
        else
        begin
            if (pool_full)
            begin
                rsp_next.status = fbpa_pkg::STATUS_FULL;
            end
            else if (put_ok)
            begin
                head_next = {1'b0, ret_reg};
                free_next = free_reg + CNT_W'(1);
            end
        end
        rsp_next.free_count = free_next;
        rsp_next.used_count = eff_count - free_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= '0;
            bytes_reg    <= fbpa_pkg::BYTES_W'(4);
            count_reg    <= CNT_W'(fbpa_pkg::MAX_BLOCKS);
            head_reg     <= '0;
            free_reg     <= CNT_W'(fbpa_pkg::MAX_BLOCKS);
            link_vld_reg <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == fbpa_pkg::CFG_BASE_ADDRESS))
            begin
                base_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == fbpa_pkg::CFG_BLOCK_BYTES))
            begin
                bytes_reg <= cfg_data[fbpa_pkg::BYTES_W-1:0];
            end
            if (cfg_count_wr)
            begin
                count_reg    <= cfg_data[CNT_W-1:0];
                head_reg     <= '0;
                free_reg     <= clamp_count(cfg_data[CNT_W-1:0]);
                link_vld_reg <= '0;
            end
            else if (dp_cmd.commit)
            begin
                head_reg <= head_next;
                free_reg <= free_next;
                if (cmd_reg == fbpa_pkg::CMD_PUT && put_ok)
                begin
                    link_vld_reg[ret_reg] <= 1'b1;
                end
            end
        end
    end

    // link memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (dp_cmd.commit && (cmd_reg == fbpa_pkg::CMD_PUT) && put_ok)
        begin
            link_mem[ret_reg] <= head_reg;
        end
        if (dp_cmd.capture)
        begin
            link_rd_reg <= link_mem[head_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            cmd_reg         <= req.cmd;
            ret_reg         <= req.return_index;
            link_vld_rd_reg <= link_vld_reg[head_reg[IDX_W-1:0]];
            prod_reg        <= head_reg[IDX_W-1:0] * bytes_reg;
        end
        if (dp_cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (dp_cmd.commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign dp_status.rsp_slot_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid               = rsp_valid_reg;
    assign rsp                     = rsp_reg;

endmodule

### sv/fixed_block_pool_allocator_top.sv
// Fixed block pool allocator: LIFO free list of up to 256 equal-size blocks.
// A request is taken only in idle; its response register loads from the execute
// state, which waits while an earlier response is still not taken.
// No new request is taken until the current one has committed.
// The response register lets the next request in while a response waits.
// Reset: base 0, block size 4, 256 blocks, list 0..255 ascending; link valid
// bits clear at once, so no clearing pass. Depends on fbpa_pkg, fbpa_ctrl, fbpa_datapath.
module fixed_block_pool_allocator_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  fbpa_pkg::req_t                       req,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output fbpa_pkg::rsp_t                       rsp
);

    fbpa_pkg::ctrl_cmd_t  dp_cmd;
    fbpa_pkg::dp_status_t dp_status;

    fbpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    fbpa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for fixed_block_pool_allocator_top: free-list predictor,
// valid/ready request and response channels, register writes between phases.
// Depends on fbpa_pkg and the allocator RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            req_valid = 1'b0;
    logic                            req_ready;
    fbpa_pkg::req_t                  req = '0;
    logic                            rsp_valid;
    logic                            rsp_ready = 1'b0;
    fbpa_pkg::rsp_t                  rsp;

    fixed_block_pool_allocator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predicted allocator state
    logic [31:0] reg_base = 32'd0;
    logic [15:0] reg_bytes = 16'd4;
    logic [8:0]  reg_count = 9'd256;
    logic [8:0]  pool_link [fbpa_pkg::MAX_BLOCKS];
    logic [8:0]  pool_head;
    int          pool_free;

    // stimulus side view of which blocks are out, used to pick put indices
    int gen_count;
    int gen_free[$];
    int gen_held[$];

    fbpa_pkg::req_t pending_reqs[$];
    fbpa_pkg::rsp_t expected_rsps[$];

    int req_issue_count = 0;
    int req_accept_count = 0;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int stall_cycles = 0;
    int mismatches = 0;
    int rsp_checked = 0;
    int grants = 0;
    int empty_hits = 0;
    int full_hits = 0;

    function automatic int usable_blocks();
        if (reg_count == 9'd0)
            return 1;
        if (reg_count > fbpa_pkg::MAX_BLOCKS)
            return fbpa_pkg::MAX_BLOCKS;
        return int'(reg_count);
    endfunction

    function automatic void reset_pool();
        for (int i = 0; i < fbpa_pkg::MAX_BLOCKS; i++)
            pool_link[i] = 9'(i + 1);
        pool_head = 9'd0;
        pool_free = usable_blocks();
    endfunction

    function automatic void gen_reinit();
        gen_count = usable_blocks();
        gen_free.delete();
        gen_held.delete();
        for (int i = 0; i < gen_count; i++)
            gen_free.push_back(i);
    endfunction

    function automatic fbpa_pkg::rsp_t allocate_or_release(fbpa_pkg::req_t r);
        int             cnt;
        logic [8:0]     h;
        fbpa_pkg::rsp_t e;
        cnt = usable_blocks();
        e = '0;
        e.status = fbpa_pkg::STATUS_OK;
        if (pool_free > cnt)
            pool_free = cnt;
        if (r.cmd == fbpa_pkg::CMD_GET)
        begin
            if (pool_free > 0)
            begin
                h = pool_head;
                e.granted_index = h[7:0];
                e.granted_address = reg_base + {23'd0, h} * {16'd0, reg_bytes};
                if (h < fbpa_pkg::MAX_BLOCKS)
                    pool_head = pool_link[h[7:0]];
                pool_free--;
            end
            else
                e.status = fbpa_pkg::STATUS_EMPTY;
        end
        else
        begin
            if (pool_free >= cnt)
                e.status = fbpa_pkg::STATUS_FULL;
            else if (r.return_index < cnt)
            begin
                // a block that is already free goes on the list again
                pool_link[r.return_index] = pool_head;
                pool_head = {1'b0, r.return_index};
                pool_free++;
            end
        end
        e.free_count = 9'(pool_free);
        e.used_count = 9'(cnt - pool_free);
        return e;
    endfunction

    task automatic queue_request(fbpa_pkg::cmd_t c, logic [7:0] idx);
        fbpa_pkg::req_t r;
        bit             found;
        r.cmd = c;
        r.return_index = idx;
        pending_reqs.push_back(r);
        if (c == fbpa_pkg::CMD_GET)
        begin
            if (gen_free.size() > 0)
                gen_held.push_back(gen_free.pop_front());
        end
        else if (gen_free.size() < gen_count && idx < gen_count)
        begin
            gen_free.push_front(int'(idx));
            found = 1'b0;
            for (int k = 0; k < gen_held.size(); k++)
                if (!found && gen_held[k] == int'(idx))
                begin
                    gen_held.delete(k);
                    found = 1'b1;
                end
        end
    endtask

    // bursts of mostly gets then mostly puts, so small pools run empty and full
    task automatic queue_random(int n);
        int         burst;
        int         r;
        int         pick;
        bit         take;
        bit         want_get;
        logic [7:0] idx;
        take = 1'b0;
        burst = 0;
        for (int i = 0; i < n; i++)
        begin
            if (burst == 0)
            begin
                take = ~take;
                burst = $urandom_range(3, (gen_count < 27) ? gen_count + 3 : 30);
            end
            burst--;
            r = $urandom_range(0, 99);
            idx = 8'($urandom);
            want_get = take ? (r < 80) : (r >= 84);
            if (r < 8)
                queue_request(fbpa_pkg::cmd_t'($urandom_range(0, 1)), idx);
            else if (want_get)
                queue_request(fbpa_pkg::CMD_GET, idx);
            else if (gen_held.size() > 0)
            begin
                pick = $urandom_range(0, gen_held.size() - 1);
                queue_request(fbpa_pkg::CMD_PUT, 8'(gen_held[pick]));
            end
            else
                queue_request(fbpa_pkg::CMD_PUT, idx);
        end
    endtask

    task automatic write_reg(fbpa_pkg::cfg_reg_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            fbpa_pkg::CFG_BASE_ADDRESS: reg_base = value;
            fbpa_pkg::CFG_BLOCK_BYTES:  reg_bytes = value[15:0];
            fbpa_pkg::CFG_BLOCK_COUNT:
            begin
                reg_count = value[8:0];
                reset_pool();
                gen_reinit();
            end
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || req_accept_count != req_issue_count ||
               expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_accept_count == req_issue_count)
        begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                req <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                req_issue_count++;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // response receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    // check responses first so a response never pairs with a request taken at the same edge
    always @(posedge clk)
    begin : monitor
        fbpa_pkg::rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                rsp_checked++;
                if (expected_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response: status %0d index %0d addr %h",
                                 rsp.status, rsp.granted_index, rsp.granted_address);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    case (want.status)
                        fbpa_pkg::STATUS_EMPTY: empty_hits++;
                        fbpa_pkg::STATUS_FULL:  full_hits++;
                        default: ;
                    endcase
                    if (want.status == fbpa_pkg::STATUS_OK && want.granted_address != 32'd0)
                        grants++;
                    if (rsp.status !== want.status ||
                        rsp.granted_index !== want.granted_index ||
                        rsp.granted_address !== want.granted_address ||
                        rsp.free_count !== want.free_count ||
                        rsp.used_count !== want.used_count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("response %0d mismatch: expected st %0d idx %0d addr %h free %0d used %0d",
                                     rsp_checked, want.status, want.granted_index,
                                     want.granted_address, want.free_count, want.used_count);
                            $display("    got st %0d idx %0d addr %h free %0d used %0d",
                                     rsp.status, rsp.granted_index, rsp.granted_address,
                                     rsp.free_count, rsp.used_count);
                        end
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                expected_rsps.push_back(allocate_or_release(req));
                req_accept_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("fixed_block_pool_allocator_top test failed");
            $finish;
        end
    end

    initial
    begin
        reset_pool();
        gen_reinit();
        sender_idle_pct = 7;
        receiver_idle_pct = 76;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values: 256 blocks of 4 bytes at 0, double free of a never used block
        queue_request(fbpa_pkg::CMD_GET, 8'hFF);
        queue_request(fbpa_pkg::CMD_GET, 8'h00);
        queue_request(fbpa_pkg::CMD_PUT, 8'd0);
        queue_request(fbpa_pkg::CMD_PUT, 8'd255);
        drain();

        // two blocks, address wraps past 2^32, upper data bits ignored
        write_reg(fbpa_pkg::CFG_BASE_ADDRESS, 32'hFFFF_FFF0);
        write_reg(fbpa_pkg::CFG_BLOCK_BYTES, 32'h0000_FFFF);
        write_reg(fbpa_pkg::CFG_BLOCK_COUNT, 32'hFFFF_FE02);
        queue_request(fbpa_pkg::CMD_GET, 8'h00);
        queue_request(fbpa_pkg::CMD_GET, 8'h00);
        queue_request(fbpa_pkg::CMD_GET, 8'hA5);
        queue_request(fbpa_pkg::CMD_PUT, 8'd200);
        queue_request(fbpa_pkg::CMD_PUT, 8'd1);
        queue_request(fbpa_pkg::CMD_PUT, 8'd1);
        queue_request(fbpa_pkg::CMD_PUT, 8'd0);
        queue_request(fbpa_pkg::CMD_GET, 8'h00);
        queue_request(fbpa_pkg::CMD_GET, 8'h00);
        drain();

        // base and size change with the list left as it is; zero block size
        write_reg(fbpa_pkg::CFG_BASE_ADDRESS, 32'h1234_5678);
        write_reg(fbpa_pkg::CFG_BLOCK_BYTES, 32'hFFFF_0000);
        queue_request(fbpa_pkg::CMD_PUT, 8'd1);
        queue_request(fbpa_pkg::CMD_GET, 8'h5A);
        drain();

        // zero count acts as one block
        write_reg(fbpa_pkg::CFG_BLOCK_COUNT, 32'hABCD_EE00);
        queue_request(fbpa_pkg::CMD_GET, 8'h00);
        queue_request(fbpa_pkg::CMD_GET, 8'h00);
        queue_request(fbpa_pkg::CMD_PUT, 8'd0);
        queue_request(fbpa_pkg::CMD_PUT, 8'd0);
        queue_request(fbpa_pkg::CMD_PUT, 8'd1);
        drain();

        // count above the maximum clamps to 256; block size below a link word
        write_reg(fbpa_pkg::CFG_BLOCK_COUNT, 32'h0000_01FF);
        write_reg(fbpa_pkg::CFG_BLOCK_BYTES, 32'h0000_0003);
        queue_request(fbpa_pkg::CMD_GET, 8'h00);
        queue_request(fbpa_pkg::CMD_GET, 8'h00);
        queue_request(fbpa_pkg::CMD_PUT, 8'd255);
        queue_request(fbpa_pkg::CMD_GET, 8'h00);
        queue_request(fbpa_pkg::CMD_PUT, 8'd0);

        for (int seg = 0; seg < 6; seg++)
        begin
            drain();
            if (seg == 2)
            begin
                sender_idle_pct = 76;
                receiver_idle_pct = 7;
            end
            if (seg == 4)
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            case (seg)
                0:
                begin
                    write_reg(fbpa_pkg::CFG_BASE_ADDRESS, $urandom);
                    write_reg(fbpa_pkg::CFG_BLOCK_BYTES, $urandom_range(4, 64));
                    write_reg(fbpa_pkg::CFG_BLOCK_COUNT, 32'd8);
                end
                1:
                begin
                    write_reg(fbpa_pkg::CFG_BASE_ADDRESS, 32'd0);
                    write_reg(fbpa_pkg::CFG_BLOCK_BYTES, 32'd4);
                    write_reg(fbpa_pkg::CFG_BLOCK_COUNT, 32'd1);
                end
                2:
                begin
                    write_reg(fbpa_pkg::CFG_BASE_ADDRESS, 32'hFFFF_FFFF);
                    write_reg(fbpa_pkg::CFG_BLOCK_BYTES, 32'h0000_FFFF);
                    write_reg(fbpa_pkg::CFG_BLOCK_COUNT, 32'd256);
                end
                3:
                begin
                    write_reg(fbpa_pkg::CFG_BASE_ADDRESS, $urandom);
                    write_reg(fbpa_pkg::CFG_BLOCK_BYTES, $urandom);
                end
                4:
                begin
                    write_reg(fbpa_pkg::CFG_BLOCK_BYTES, $urandom_range(4, 65535));
                    write_reg(fbpa_pkg::CFG_BLOCK_COUNT,
                              ($urandom & 32'hFFFF_FE00) | $urandom_range(2, 16));
                end
                default:
                begin
                    write_reg(fbpa_pkg::CFG_BASE_ADDRESS, $urandom);
                    write_reg(fbpa_pkg::CFG_BLOCK_COUNT, $urandom_range(17, 64));
                end
            endcase
            queue_random(72);
        end

        drain();
        repeat (4) @(posedge clk);
        $display("%0d requests over block counts 1 to 256, three idle mixes", req_issue_count);
        $display("%0d responses checked: %0d nonzero grants, %0d empty gets, %0d full puts",
                 rsp_checked, grants, empty_hits, full_hits);
        if (mismatches == 0)
            $display("fixed_block_pool_allocator_top test passed");
        else
            $display("fixed_block_pool_allocator_top test failed");
        $finish;
    end

endmodule
